@@ rtl/csvt_pkg.sv @@
`timescale 1ns / 1ps
// shared types and constants for the csv field tokenizer
package csvt_pkg;

  localparam int unsigned CharW  = 8;
  localparam int unsigned IndexW = 8;

  localparam logic [CharW-1:0] DelimReset = 8'd44;
  localparam logic [CharW-1:0] QuoteReset = 8'd34;

  // configuration register indexes
  typedef enum logic [0:0] {
    REG_DELIMITER = 1'b0,
    REG_QUOTE     = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [CharW-1:0] delimiter_char;
    logic [CharW-1:0] quote_char;
  } cfg_t;

  typedef struct packed {
    logic              unterminated_quote;
    logic              line_end;
    logic [IndexW-1:0] field_index;
    logic              field_end;
    logic              is_data;
    logic [CharW-1:0]  data_byte;
  } result_t;

endpackage

@@ rtl/csvt_cfg.sv @@
`timescale 1ns / 1ps
// delimiter and quote configuration registers
module csvt_cfg (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [0:0]           cfg_index,
  input  logic [7:0]           cfg_data,
  output csvt_pkg::cfg_t       cfg
);
  import csvt_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.delimiter_char <= DelimReset;
      cfg.quote_char     <= QuoteReset;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_DELIMITER: cfg.delimiter_char <= cfg_data;
        REG_QUOTE:     cfg.quote_char     <= cfg_data;
        default:       cfg.quote_char     <= cfg.quote_char;
      endcase
    end
  end

endmodule

@@ rtl/csvt_core.sv @@
`timescale 1ns / 1ps
// quote state, field counter and per-byte result decode
module csvt_core #(
  parameter int unsigned FieldLimit = 255
) (
  input  logic                 clk,
  input  logic                 rst,
  input  csvt_pkg::cfg_t       cfg,
  input  logic                 in_fire,
  input  logic [7:0]           char_in,
  input  logic                 end_of_line,
  output logic                 res_valid,
  output csvt_pkg::result_t    res
);
  import csvt_pkg::*;

  logic              in_quotes, in_quotes_next;
  logic              quote_pending, quote_pending_next;
  logic [IndexW-1:0] field_counter, field_counter_next;
  logic              is_quote, is_delim;
  logic              emit;

  assign is_quote = (char_in == cfg.quote_char);
  assign is_delim = (char_in == cfg.delimiter_char);

  always_comb begin
    in_quotes_next     = in_quotes;
    quote_pending_next = quote_pending;
    field_counter_next = field_counter;
    emit               = 1'b0;
    res                = '0;
    res.field_index    = field_counter;
    if (end_of_line) begin
      // a pending quote closes quoted mode, so only an open quote is an error
      emit                   = 1'b1;
      res.line_end           = 1'b1;
      res.unterminated_quote = in_quotes && !quote_pending;
      res.field_end          = !(in_quotes && !quote_pending);
      in_quotes_next         = 1'b0;
      quote_pending_next     = 1'b0;
      field_counter_next     = '0;
    end else if (quote_pending && is_quote) begin
      // doubled quote gives one literal quote
      emit               = 1'b1;
      res.is_data        = 1'b1;
      res.data_byte      = char_in;
      quote_pending_next = 1'b0;
    end else if (in_quotes && !quote_pending) begin
      if (is_quote) begin
        quote_pending_next = 1'b1;
      end else begin
        emit          = 1'b1;
        res.is_data   = 1'b1;
        res.data_byte = char_in;
      end
    end else begin
      // unquoted byte, possibly right after a closing quote
      quote_pending_next = 1'b0;
      in_quotes_next     = 1'b0;
      if (is_quote) begin
        in_quotes_next = 1'b1;
      end else if (is_delim) begin
        emit          = 1'b1;
        res.field_end = 1'b1;
        if (field_counter < IndexW'(FieldLimit)) begin
          field_counter_next = field_counter + 1'b1;
        end
      end else begin
        emit          = 1'b1;
        res.is_data   = 1'b1;
        res.data_byte = char_in;
      end
    end
  end

  assign res_valid = in_fire && emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_quotes     <= 1'b0;
      quote_pending <= 1'b0;
      field_counter <= '0;
    end else if (in_fire) begin
      in_quotes     <= in_quotes_next;
      quote_pending <= quote_pending_next;
      field_counter <= field_counter_next;
    end
  end

endmodule

@@ rtl/csvt_skid.sv @@
`timescale 1ns / 1ps
// output register with a skid stage for the result stream
module csvt_skid (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  csvt_pkg::result_t    in_res,
  output logic                 out_valid,
  input  logic                 out_ready,
  output csvt_pkg::result_t    out_res
);
  import csvt_pkg::*;

  logic    skid_valid;
  result_t skid_res;

  assign in_ready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_ready || !out_valid) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        out_res    <= skid_res;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= in_valid;
        out_res   <= in_res;
      end
    end else if (in_valid) begin
      // output stalled, park the new item
      skid_valid <= 1'b1;
      skid_res   <= in_res;
    end
  end

endmodule

@@ rtl/csv_field_tokenizer.sv @@
`timescale 1ns / 1ps
// top level: one byte or end-of-line item in, at most one result item out
// output: each result is registered in the output stage, or parked in the skid stage while the output stalls
// throughput: one item per cycle; ready is held low only while the skid stage is full
// reset (rst, synchronous): quote state and field counter clear, delimiter ','
// and quote '"' reload, output and skid stages empty
module csv_field_tokenizer #(
  parameter int unsigned MAX_FIELDS = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] char_in
  input  logic        s_axis_tlast,   // end_of_line
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] data_byte, [15:8] field_index
  output logic [2:0]  m_axis_tuser,   // [0] is_data, [1] field_end, [2] unterminated_quote
  output logic        m_axis_tlast    // line_end
);
  import csvt_pkg::*;

  localparam int unsigned FieldLimit = (MAX_FIELDS - 1 > 255) ? 255 : MAX_FIELDS - 1;

  cfg_t    cfg;
  result_t res, out_res;
  logic    res_valid, in_fire;

  assign in_fire = s_axis_tvalid && s_axis_tready;

  csvt_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  csvt_core #(
    .FieldLimit (FieldLimit)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_fire     (in_fire),
    .char_in     (s_axis_tdata),
    .end_of_line (s_axis_tlast),
    .res_valid   (res_valid),
    .res         (res)
  );

  csvt_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (res_valid),
    .in_ready  (s_axis_tready),
    .in_res    (res),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_res   (out_res)
  );

  assign m_axis_tdata = {out_res.field_index, out_res.data_byte};
  assign m_axis_tuser = {out_res.unterminated_quote, out_res.field_end, out_res.is_data};
  assign m_axis_tlast = out_res.line_end;

endmodule
